// File: design/sck_pkg.sv
`timescale 1ns / 1ps

package sck_pkg;

  // channel layout of one pixel: lane 0 red, lane 1 green, lane 2 blue
  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  // result position fields
  localparam int ROW_W = 16;
  localparam int COL_W = 11;

  // configuration registers
  localparam int WID_W = 12;
  localparam int HGT_W = 16;

  localparam logic [WID_W-1:0] WID_RST = 12'd640;
  localparam logic [HGT_W-1:0] HGT_RST = 16'd480;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // upper clamping limit of the sharpened value
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

endpackage

// File: design/sck_lane.sv
`timescale 1ns / 1ps

module sck_lane
  import sck_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [CH_W-1:0] top,
  input  logic [CH_W-1:0] left,
  input  logic [CH_W-1:0] mid,
  input  logic [CH_W-1:0] right,
  input  logic [CH_W-1:0] bot,
  output logic [CH_W-1:0] sharp
);

  logic signed [CH_W+3:0] times5;
  logic signed [CH_W+3:0] neigh;
  logic signed [CH_W+3:0] diff;
  logic        [CH_W-1:0] sharp_nxt;
  logic        [CH_W-1:0] sharp_r;

  // five times the centre minus the four neighbours
  always_comb begin
    times5 = $signed({2'b00, mid, 2'b00}) + $signed({4'b0000, mid});
    neigh  = $signed({4'b0000, top}) + $signed({4'b0000, left})
           + $signed({4'b0000, right}) + $signed({4'b0000, bot});
    diff   = times5 - neigh;
  end

  // clamp to the channel range
  always_comb begin
    if (diff < 0) begin
      sharp_nxt = '0;
    end else if (diff > $signed({4'b0000, CH_MAX})) begin
      sharp_nxt = CH_MAX;
    end else begin
      sharp_nxt = diff[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sharp_r <= sharp_nxt;
    end
  end

  assign sharp = sharp_r;

endmodule

// File: design/sck_line_buf.sv
`timescale 1ns / 1ps

module sck_line_buf
  import sck_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  // pixel entering the window: previous row store read and write
  input  logic          in_en,
  input  logic [AW-1:0] in_addr,
  input  logic [AW-1:0] in_addr_next,
  input  pix_t          in_pix,
  // older row store refill from the previous row value
  input  logic          old_we,
  input  logic [AW-1:0] old_addr,
  input  pix_t          old_pix,
  output pix_t          rd_mid,
  output pix_t          rd_right,
  output pix_t          rd_top
);

  pix_t prev_mem [DEPTH];
  pix_t old_mem  [DEPTH];

  pix_t mid_r;
  pix_t right_r;
  pix_t top_r;

  // previous row: one write, reads at the column and the next column
  always_ff @(posedge clk) begin
    if (in_en) begin
      mid_r              <= prev_mem[in_addr];
      right_r            <= prev_mem[in_addr_next];
      prev_mem[in_addr]  <= in_pix;
    end
  end

  // older row: read at the column, written as the window moves on
  always_ff @(posedge clk) begin
    if (in_en) begin
      top_r <= old_mem[in_addr];
    end
    if (old_we) begin
      old_mem[old_addr] <= old_pix;
    end
  end

  assign rd_mid   = mid_r;
  assign rd_right = right_r;
  assign rd_top   = top_r;

endmodule

// File: design/sharpen_cross_kernel_3x3_top.sv
`timescale 1ns / 1ps
// channel  | dir | handshake          | payload
// in_      | in  | tvalid / tready    | tdata: red, green, blue
// out_     | out | tvalid / tready    | tdata: row, col, red, green, blue; tlast; tuser
// cfg_     | in  | psel / penable     | paddr, pwdata, prdata (APB, pready tied high)
//
// one pixel per cycle without back-pressure; last-row pixels give two beats and hold the input
// first beat of a pixel leaves after the window stage, then the lane/output regs
// the line stores need no clearing pass: a value read before it is written is never output
// a registered input skid and the output register keep tready free of the output side
// rst_n is synchronous, active low; it clears counters, valids and the config registers

module sharpen_cross_kernel_3x3_top
  import sck_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // row, col, red, green, blue, zero pad
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // end of frame
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WCW = (AW + 2 > WID_W) ? AW + 2 : WID_W;

  localparam logic [WCW-1:0] MAXW_E  = WCW'(MAX_WIDTH);
  localparam logic [AW-1:0]  LAST_CO = AW'(MAX_WIDTH - 1);

  // configuration registers
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_RST;
      height_r <= HGT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) begin
        width_r <= cfg_pwdata[WID_W-1:0];
      end else begin
        height_r <= cfg_pwdata[HGT_W-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WIDTH:  cfg_prdata = {{(32-WID_W){1'b0}}, width_r};
      REG_HEIGHT: cfg_prdata = {{(32-HGT_W){1'b0}}, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // input skid
  logic skid_v_r;
  pix_t skid_pix_r;
  pix_t in_pix;
  pix_t src_pix;
  logic src_v;
  logic in_fire;
  logic p_adv;
  logic enter;

  assign in_pix    = {in_tdata[23:16], in_tdata[15:8], in_tdata[7:0]};
  assign in_tready = ~skid_v_r;
  assign in_fire   = in_tvalid & in_tready;
  assign src_v     = skid_v_r | in_tvalid;
  assign src_pix   = skid_v_r ? skid_pix_r : in_pix;
  assign enter     = src_v & p_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (p_adv) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_fire && !p_adv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !p_adv) begin
      skid_pix_r <= in_pix;
    end
  end

  // raster position and per-pixel flags
  logic [AW-1:0]    col_r;
  logic [AW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [WCW-1:0]   wid_e;
  logic [HGT_W-1:0] hgt_e;
  logic [AW-1:0]    c_e;
  logic [WCW-1:0]   c_w;
  logic             last_row;
  logic             col_wrap;
  logic             interior;
  logic             has_up;

  always_comb begin
    if (width_r == '0) begin
      wid_e = WCW'(1);
    end else if (WCW'(width_r) > MAXW_E) begin
      wid_e = MAXW_E;
    end else begin
      wid_e = WCW'(width_r);
    end
    hgt_e    = (height_r == '0) ? HGT_W'(1) : height_r;
    c_e      = (WCW'(col_r) >= MAXW_E) ? LAST_CO : col_r;
    c_w      = WCW'(c_e);
    last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, hgt_e};
    col_wrap = (c_w + WCW'(1)) >= wid_e;
    has_up   = (row_r != '0);
    interior = (row_r >= ROW_W'(2)) && (row_r < hgt_e) && (c_w >= WCW'(1))
             && ((c_w + WCW'(2)) <= wid_e) && ((c_w + WCW'(1)) < MAXW_E);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (enter) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = c_e + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // window stage: line store reads land here
  logic             s1_v_r;
  pix_t             s1_cur_r;
  logic [AW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_up_r;
  logic             s1_own_r;
  logic             s1_int_r;
  logic             s1_eof_r;
  pix_t             rd_mid;
  pix_t             rd_right;
  pix_t             rd_top;
  pix_t             left_r;
  logic             s1_go;
  logic             s2_free;

  assign s1_go = s1_v_r & s2_free;
  assign p_adv = ~s1_v_r | s2_free;

  sck_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk          (clk),
    .in_en        (enter),
    .in_addr      (c_e),
    .in_addr_next (c_e + AW'(1)),
    .in_pix       (src_pix),
    .old_we       (s1_go),
    .old_addr     (s1_col_r),
    .old_pix      (rd_mid),
    .rd_mid       (rd_mid),
    .rd_right     (rd_right),
    .rd_top       (rd_top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (enter) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      s1_cur_r <= src_pix;
      s1_col_r <= c_e;
      s1_row_r <= row_r;
      s1_up_r  <= has_up;
      s1_own_r <= last_row;
      s1_int_r <= interior;
      s1_eof_r <= col_wrap;
    end
    // the centre of this pixel is the left neighbour of the next one
    if (s1_go) begin
      left_r <= rd_mid;
    end
  end

  // one sharpening lane per channel
  pix_t sharp;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    sck_lane u_lane (
      .clk   (clk),
      .en    (s1_go),
      .top   (rd_top[ch]),
      .left  (left_r[ch]),
      .mid   (rd_mid[ch]),
      .right (rd_right[ch]),
      .bot   (s1_cur_r[ch]),
      .sharp (sharp[ch])
    );
  end

  // output register: up to two beats per pixel
  logic             s2_v_r;
  pix_t             s2_mid_r;
  pix_t             s2_cur_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_up_r;
  logic             s2_own_r;
  logic             s2_int_r;
  logic             s2_eof_r;
  logic             phase_r;
  logic             out_fire;
  logic             s2_fin;
  logic             sel_up;

  assign out_fire = out_tvalid & out_tready;
  assign s2_fin   = out_fire & out_tlast;
  assign s2_free  = ~s2_v_r | s2_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (s1_go) begin
      s2_v_r  <= s1_up_r | s1_own_r;
      phase_r <= 1'b0;
    end else if (s2_fin) begin
      s2_v_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (out_fire) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_mid_r <= rd_mid;
      s2_cur_r <= s1_cur_r;
      s2_row_r <= s1_row_r;
      s2_col_r <= COL_W'(s1_col_r);
      s2_up_r  <= s1_up_r;
      s2_own_r <= s1_own_r;
      s2_int_r <= s1_int_r;
      s2_eof_r <= s1_eof_r;
    end
  end

  // merge: row above first, then the pixel itself on the last row
  logic [ROW_W-1:0] o_row;
  pix_t             o_pix;

  always_comb begin
    sel_up = s2_up_r & ~phase_r;
    if (sel_up) begin
      o_row     = s2_row_r - ROW_W'(1);
      o_pix     = s2_int_r ? sharp : s2_mid_r;
      out_tlast = ~s2_own_r;
    end else begin
      o_row     = s2_row_r;
      o_pix     = s2_cur_r;
      out_tlast = 1'b1;
    end
  end

  assign out_tvalid   = s2_v_r;
  assign out_tuser[0] = ~sel_up & s2_eof_r;
  assign out_tdata    = {5'b00000, o_pix[2], o_pix[1], o_pix[0], s2_col_r, o_row};

`ifndef SYNTHESIS
  // end of frame only on the closing beat of a pixel
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("end of frame on a beat that is not last");

  // the beat after an inner beat is the pixel one row further down
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_tlast |=> out_tvalid
      && (out_tdata[15:0] == $past(out_tdata[15:0]) + 16'd1)
      && (out_tdata[26:16] == $past(out_tdata[26:16])))
    else $error("second beat of a pixel out of place");

  // the second phase only exists for a pixel with two results
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> s2_v_r && s2_up_r && s2_own_r)
    else $error("second beat phase without two results");
`endif

endmodule
